@@ rtl/core/alw_pkg.sv @@
// Package for the ANSI-aware line wrapper: result codes, queue record types,
// character constants and the escape-code test. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package alw_pkg;

  localparam int unsigned BYTES_W = 10;

  localparam logic [7:0] CH_ESC         = 8'h1B;
  localparam logic [7:0] CH_NL          = 8'h0A;
  localparam logic [7:0] CH_SPACE       = 8'h20;
  localparam logic [7:0] LINE_WIDTH_RST = 8'd79;

  typedef enum logic [1:0] {
    RK_CHAR     = 2'd0,
    RK_LINE_END = 2'd1,
    RK_FINISH   = 2'd2
  } rkind_e;

  typedef struct packed {
    rkind_e              kind;
    logic [7:0]          ch;
    logic [BYTES_W-1:0]  bytes;
  } result_t;

  // One input item's worth of output: one or two results.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } job_t;

  // Bytes that may follow ESC inside a CSI sequence.
  function automatic logic is_ansi_code(input logic [7:0] ch);
    logic r;
    r = ch inside {8'h5B, 8'h3B, [8'h30:8'h39]};
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ansi_aware_line_wrapper_top.sv @@
// Top level of the ANSI-aware line wrapper: front end, result queue and
// back end. Depends on alw_pkg, alw_front, alw_queue and alw_back.
//
// Cuts a byte stream into display lines of at most line_width visible
// columns and LINE_BYTES raw bytes; escape sequences take no columns,
// unprintable bytes come out as spaces, and a double-byte lead that would
// not fit opens the next line. One input item is taken per clock while the
// queue has room; each yields one or two results, sent one per clock while
// out_ready_i is high. The two-entry queue between front and back keeps
// input flowing while results wait. Output valid follows the queue
// register, with no combinational path from input to output. The width
// register is to be written through the cfg port only while the block is
// idle, which the block does not enforce; cfg_ready_o is always high.
`timescale 1ns / 1ps
`default_nettype none

module ansi_aware_line_wrapper_top import alw_pkg::*; #(
  parameter int unsigned LINE_BYTES = 512
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       kind_i,
  input  wire logic [7:0] in_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      result_kind_o,
  output logic [7:0]      out_char_o,
  output logic [9:0]      line_bytes_o,
  output logic            last_o
);

  logic q_ready, q_valid, pop, take;
  job_t job, head;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = q_ready;
  assign take        = in_valid_i && q_ready;

  alw_front #(
    .LINE_BYTES(LINE_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .take_i     (take),
    .kind_i     (kind_i),
    .in_byte_i  (in_byte_i),
    .job_o      (job)
  );

  alw_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (take),
    .push_job_i (job),
    .ready_o    (q_ready),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .head_o     (head)
  );

  alw_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (q_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .out_char_o    (out_char_o),
    .line_bytes_o  (line_bytes_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/alw_front.sv @@
// Front end of the line wrapper: holds the width register and line state,
// classifies each byte and builds its result record. Depends on alw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alw_front import alw_pkg::*; #(
  parameter int unsigned LINE_BYTES = 512
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic       take_i,
  input  wire logic       kind_i,
  input  wire logic [7:0] in_byte_i,
  output job_t            job_o
);

  localparam int unsigned RW = $clog2(LINE_BYTES + 1);
  localparam logic [RW:0] LB = (RW + 1)'(LINE_BYTES);

  logic [7:0]    line_width_q;
  logic [7:0]    col_q, col_d;
  logic [RW-1:0] raw_q, raw_d;
  logic          esc_q, esc_d, wide_q, wide_d, wp_q, wp_d, wf_q, wf_d;

  logic          is_esc, is_nl, cont_esc, pre_end, use_clear;
  logic [7:0]    bc, c0, col_n, ch_n;
  logic [RW-1:0] br, r0, r1;
  logic          be, bw, w1, brk, e0, esc_n, forced, wrap;
  logic [8:0]    col_inc;
  logic [RW:0]   raw_p2, raw1_p1;
  result_t       lead, main_r, fin;

  always_comb begin
    is_esc    = (in_byte_i == CH_ESC);
    is_nl     = (in_byte_i == CH_NL);
    cont_esc  = wp_q && is_esc && !wf_q;
    pre_end   = wp_q && !cont_esc && !is_nl;
    use_clear = wp_q && !cont_esc;

    bc = use_clear ? 8'd0 : col_q;
    br = use_clear ? '0 : raw_q;
    be = use_clear ? 1'b0 : esc_q;
    bw = use_clear ? 1'b0 : wide_q;

    // Pairing toggles on a lead byte and on whatever follows it.
    w1      = (bw || in_byte_i[7]) ? !bw : bw;
    col_inc = {1'b0, bc} + 9'd1;
    raw_p2  = {1'b0, br} + (RW + 1)'(2);
    brk     = w1 && (br != '0) &&
              ((col_inc >= {1'b0, line_width_q}) || (raw_p2 >= LB));

    c0 = brk ? 8'd0 : bc;
    r0 = brk ? '0 : br;
    e0 = brk ? 1'b0 : be;
    r1 = r0 + RW'(1);

    if (is_esc) begin
      esc_n = 1'b1;
      col_n = c0;
      ch_n  = in_byte_i;
    end else if (e0) begin
      esc_n = is_ansi_code(in_byte_i);
      col_n = c0;
      ch_n  = in_byte_i;
    end else begin
      esc_n = 1'b0;
      ch_n  = (in_byte_i[7] || (in_byte_i >= 8'h20 && in_byte_i <= 8'h7E)) ?
              in_byte_i : CH_SPACE;
      col_n = (c0 == 8'hFF) ? c0 : c0 + 8'd1;
    end

    raw1_p1 = {1'b0, r1} + (RW + 1)'(1);
    forced  = (raw1_p1 >= LB);
    wrap    = ((col_n >= line_width_q) || forced) && !(esc_n && !forced);

    fin  = '{kind: RK_FINISH, ch: 8'd0, bytes: '0};
    lead = '{kind: RK_LINE_END, ch: 8'd0,
             bytes: brk ? BYTES_W'(br) : BYTES_W'(raw_q)};
    if (is_nl) begin
      main_r = '{kind: RK_LINE_END, ch: 8'd0, bytes: BYTES_W'(r1)};
    end else begin
      main_r = '{kind: RK_CHAR, ch: ch_n, bytes: '0};
    end

    col_d  = '0;
    raw_d  = '0;
    esc_d  = 1'b0;
    wide_d = 1'b0;
    wp_d   = 1'b0;
    wf_d   = 1'b0;

    if (kind_i) begin
      job_o.two    = (raw_q != '0);
      job_o.first  = (raw_q != '0) ?
                     '{kind: RK_LINE_END, ch: 8'd0, bytes: BYTES_W'(raw_q)} : fin;
      job_o.second = fin;
    end else if (wp_q && is_nl) begin
      // Newline right after a full line is absorbed into it.
      job_o.two    = 1'b0;
      job_o.first  = '{kind: RK_LINE_END, ch: 8'd0,
                       bytes: BYTES_W'(raw_q + RW'(1))};
      job_o.second = fin;
    end else begin
      job_o.two    = brk || pre_end;
      job_o.first  = (brk || pre_end) ? lead : main_r;
      job_o.second = main_r;
      if (!is_nl) begin
        col_d  = col_n;
        raw_d  = r1;
        esc_d  = esc_n;
        wide_d = w1;
        wp_d   = wrap;
        wf_d   = wrap && forced;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RST;
      col_q        <= '0;
      raw_q        <= '0;
      esc_q        <= 1'b0;
      wide_q       <= 1'b0;
      wp_q         <= 1'b0;
      wf_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        line_width_q <= cfg_data_i;
      end
      if (take_i) begin
        col_q  <= col_d;
        raw_q  <= raw_d;
        esc_q  <= esc_d;
        wide_q <= wide_d;
        wp_q   <= wp_d;
        wf_q   <= wf_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/alw_queue.sv @@
// Two-entry queue of result records between the front and back ends of the
// line wrapper. Depends on alw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alw_queue import alw_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      push_job_i,
  output logic      ready_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output job_t      head_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign ready_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/alw_back.sv @@
// Back end of the line wrapper: walks the one or two results of the queue
// head onto the output channel and marks the last one. Depends on alw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alw_back import alw_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                head_valid_i,
  input  job_t                     head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [1:0]               result_kind_o,
  output logic [7:0]               out_char_o,
  output logic [BYTES_W-1:0]       line_bytes_o,
  output logic                     last_o
);

  logic    sel_q, sel_d;
  logic    xfer;
  result_t cur;

  assign cur           = sel_q ? head_i.second : head_i.first;
  assign out_valid_o   = head_valid_i;
  assign result_kind_o = cur.kind;
  assign out_char_o    = cur.ch;
  assign line_bytes_o  = cur.bytes;
  assign last_o        = sel_q || !head_i.two;
  assign xfer          = head_valid_i && out_ready_i;
  assign pop_o         = xfer && last_o;

  always_comb begin
    sel_d = sel_q;
    if (xfer) begin
      sel_d = !last_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/alw_checker.sv @@
// Port-level checks for the ANSI-aware line wrapper, bound to the top level.
// Depends on alw_pkg and ansi_aware_line_wrapper_top.
`timescale 1ns / 1ps
`default_nettype none

module alw_checker import alw_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [1:0] result_kind_i,
  input wire logic [7:0] out_char_i,
  input wire logic [9:0] line_bytes_i,
  input wire logic       last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped before transfer");

  a_finish_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && result_kind_i == RK_FINISH |-> last_i)
    else $error("input finished is not the last result");

  a_char_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && result_kind_i == RK_CHAR |-> line_bytes_i == '0 && last_i)
    else $error("character result with byte count or not last");

  a_end_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && result_kind_i != RK_CHAR |-> out_char_i == 8'd0)
    else $error("line end or finish with nonzero char");

endmodule

bind ansi_aware_line_wrapper_top alw_checker u_alw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_kind_i (result_kind_o),
  .out_char_i    (out_char_o),
  .line_bytes_i  (line_bytes_o),
  .last_i        (last_o)
);

`default_nettype wire

@@ tb/ansi_aware_line_wrapper_top_tb.sv @@
// Self-checking testbench for ansi_aware_line_wrapper_top: a directed pass, then random
// text with escapes, double-byte pairs and over-long lines under several line widths.
// Depends on alw_pkg and the RTL of the block.
`timescale 1ns / 1ps

module ansi_aware_line_wrapper_top_tb;
  import alw_pkg::*;

  localparam int unsigned LINE_BYTES   = 512;
  localparam int unsigned HALF_PERIOD  = 5;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned LIMIT_NS     = 4_000_000;
  localparam int unsigned MAX_PRINTS   = 25;

  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_M        = 8'h6D;

  typedef struct packed {
    logic       eoi;
    logic [7:0] b;
  } text_item_t;

  typedef struct packed {
    rkind_e     kind;
    logic [7:0] ch;
    logic [9:0] nbytes;
    logic       last;
  } line_res_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic [7:0] cfg_data_i  = 8'd0;
  logic       in_valid_i  = 1'b0;
  logic       kind_i      = 1'b0;
  logic [7:0] in_byte_i   = 8'd0;
  logic       out_ready_i = 1'b0;
  logic       cfg_ready_o;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] result_kind_o;
  logic [7:0] out_char_o;
  logic [9:0] line_bytes_o;
  logic       last_o;

  ansi_aware_line_wrapper_top #(
    .LINE_BYTES(LINE_BYTES)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_kind_o(result_kind_o),
    .out_char_o   (out_char_o),
    .line_bytes_o (line_bytes_o),
    .last_o       (last_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Stimulus and expectation stores
  text_item_t  byte_q[$];
  line_res_t   wrapped_q[$];
  line_res_t   step_out[$];
  text_item_t  tx_cur;
  bit          in_busy;
  bit          hold_tx;
  int unsigned rx_hold;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  // Predictor state
  int unsigned width_r;
  int unsigned col_cnt;
  int unsigned raw_cnt;
  bit          esc_on;
  bit          wide_on;
  bit          wrap_on;
  bit          wrap_hard;

  // Bookkeeping
  int unsigned err_cnt;
  int unsigned pushed;
  int unsigned n_items;
  int unsigned n_lines;
  int unsigned n_finish;
  int unsigned n_splits;
  int unsigned n_forced;
  int unsigned n_widths;
  int unsigned n_in_stalls;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (err_cnt < MAX_PRINTS) begin
      $display("[%0t] mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
    end
    err_cnt++;
  endtask

  // ---------------------------------------------------------------- predictor
  function automatic bit is_csi_byte(input logic [7:0] c);
    return c == CH_LBRACKET || c == CH_SEMI || (c >= CH_ZERO && c <= CH_NINE);
  endfunction

  task automatic clear_line_state();
    col_cnt   = 0;
    raw_cnt   = 0;
    esc_on    = 1'b0;
    wide_on   = 1'b0;
    wrap_on   = 1'b0;
    wrap_hard = 1'b0;
  endtask

  task automatic emit(input rkind_e k, input logic [7:0] c, input int unsigned nb);
    line_res_t r;
    r.kind   = k;
    r.ch     = c;
    r.nbytes = 10'(nb);
    r.last   = 1'b0;
    step_out.push_back(r);
  endtask

  task automatic close_line();
    emit(RK_LINE_END, 8'd0, raw_cnt);
    clear_line_state();
  endtask

  task automatic place_byte(input logic [7:0] c);
    logic [7:0] shown;
    bit         forced;
    shown = c;
    if (wide_on || c[7]) wide_on = !wide_on;
    // lead byte that does not fit moves to a fresh line
    if (wide_on && raw_cnt > 0 &&
        (col_cnt + 1 >= width_r || raw_cnt + 2 >= LINE_BYTES)) begin
      close_line();
      wide_on = 1'b1;
      n_splits++;
    end
    raw_cnt++;
    if (c == CH_NL) begin
      close_line();
    end else begin
      if (c == CH_ESC) begin
        esc_on = 1'b1;
      end else if (esc_on) begin
        if (!is_csi_byte(c)) esc_on = 1'b0;
      end else begin
        if (!(c[7] || (c >= 8'h20 && c <= 8'h7E))) shown = CH_SPACE;
        if (col_cnt < 255) col_cnt++;
      end
      emit(RK_CHAR, shown, 0);
      forced = (raw_cnt + 1 >= LINE_BYTES);
      // an open escape may run past the width, but not past the byte limit
      if ((col_cnt >= width_r || forced) && !(esc_on && !forced)) begin
        wrap_on   = 1'b1;
        wrap_hard = forced;
        if (forced) n_forced++;
      end
    end
  endtask

  task automatic predict_wrap(input logic eoi, input logic [7:0] b);
    line_res_t r;
    step_out.delete();
    if (eoi) begin
      if (raw_cnt > 0) close_line();
      clear_line_state();
      emit(RK_FINISH, 8'd0, 0);
    end else if (wrap_on) begin
      if (b == CH_ESC && !wrap_hard) begin
        wrap_on = 1'b0;
        place_byte(b);
      end else if (b == CH_NL) begin
        raw_cnt++;
        close_line();
      end else begin
        close_line();
        place_byte(b);
      end
    end else begin
      place_byte(b);
    end
    foreach (step_out[i]) begin
      r      = step_out[i];
      r.last = (i == step_out.size() - 1);
      wrapped_q.push_back(r);
    end
  endtask

  task automatic check_result();
    line_res_t want;
    if (wrapped_q.size() == 0) begin
      report_mismatch("result with nothing expected, kind", result_kind_o, 0);
    end else begin
      want = wrapped_q.pop_front();
      if (result_kind_o !== want.kind) report_mismatch("result_kind", result_kind_o, want.kind);
      if (out_char_o !== want.ch) report_mismatch("out_char", out_char_o, want.ch);
      if (line_bytes_o !== want.nbytes) report_mismatch("line_bytes", line_bytes_o, want.nbytes);
      if (last_o !== want.last) report_mismatch("last", last_o, want.last);
      if (want.kind == RK_LINE_END) n_lines++;
      if (want.kind == RK_FINISH) n_finish++;
    end
  endtask

  // ---------------------------------------------------------------- driver / receiver / monitor
  always @(negedge clk_i) begin
    if (rst_ni && !in_busy) begin
      if (!hold_tx && byte_q.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        tx_cur = byte_q.pop_front();
        in_valid_i <= 1'b1;
        kind_i     <= tx_cur.eoi;
        in_byte_i  <= tx_cur.b;
        in_busy = 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rx_hold > 0) begin
      out_ready_i <= 1'b0;
      rx_hold--;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_wrap(kind_i, in_byte_i);
        in_busy = 1'b0;
        n_items++;
      end
      if (in_valid_i && !in_ready_o) n_in_stalls++;
      if (out_valid_o && out_ready_i) check_result();
    end
  end

  // ---------------------------------------------------------------- stimulus helpers
  task automatic push_byte(input logic [7:0] b);
    text_item_t t;
    t.eoi = 1'b0;
    t.b   = b;
    byte_q.push_back(t);
    pushed++;
  endtask

  task automatic push_eoi();
    text_item_t t;
    t.eoi = 1'b1;
    t.b   = 8'($urandom_range(0, 255));
    byte_q.push_back(t);
    pushed++;
  endtask

  task automatic wait_drained();
    while (byte_q.size() != 0 || in_busy || wrapped_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_width(input logic [7:0] w);
    wait_drained();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    width_r = w;
    n_widths++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One chunk of text: words, CSI sequences, double-byte pairs, newlines, noise, end-of-input marks.
  task automatic add_segment();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      len = $urandom_range(1, 12);
      repeat (len) push_byte(8'($urandom_range(8'h21, 8'h7E)));
      push_byte(($urandom_range(0, 3) == 0) ? CH_NL : CH_SPACE);
    end else if (pick < 50) begin
      push_byte(CH_ESC);
      push_byte(CH_LBRACKET);
      len = $urandom_range(0, 6);
      repeat (len) begin
        push_byte(($urandom_range(0, 4) == 0) ? CH_SEMI : 8'($urandom_range(CH_ZERO, CH_NINE)));
      end
      push_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : CH_M);
    end else if (pick < 65) begin
      push_byte(8'($urandom_range(8'h80, 8'hFF)));
      push_byte(8'($urandom_range(8'h40, 8'hFE)));
    end else if (pick < 74) begin
      push_byte(CH_NL);
    end else if (pick < 84) begin
      push_byte(8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      // lead byte left dangling by a newline or ESC
      push_byte(8'($urandom_range(8'h80, 8'hFF)));
      push_byte($urandom_range(0, 1) ? CH_NL : CH_ESC);
    end else if (pick < 93) begin
      push_eoi();
    end else begin
      push_byte(8'($urandom_range(0, 31)));
    end
  endtask

  task automatic queue_random(input int unsigned n);
    int unsigned start;
    start = pushed;
    while (pushed - start < n) add_segment();
  endtask

  // CSI run that ends exactly at the byte limit, then ESC, which must not continue it.
  task automatic queue_forced_escape();
    push_byte(CH_ESC);
    push_byte(CH_LBRACKET);
    repeat (LINE_BYTES - 3) push_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
    push_byte(CH_ESC);
    push_byte(CH_LBRACKET);
    push_byte(CH_M);
    push_byte(CH_NL);
  endtask

  // Plain line past the widest setting, then a CSI run leaving room for no pair.
  task automatic queue_long_lines();
    repeat ($urandom_range(258, 270)) push_byte(8'($urandom_range(8'h21, 8'h7E)));
    push_byte(CH_NL);
    push_byte(CH_ESC);
    push_byte(CH_LBRACKET);
    repeat (LINE_BYTES - 4) push_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
    push_byte(8'($urandom_range(8'h80, 8'hFF)));
    push_byte(8'($urandom_range(8'h40, 8'hFE)));
    push_eoi();
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    logic [7:0] seq[$];
    tx_idle_pct = 16;
    rx_idle_pct = 74;
    width_r = LINE_WIDTH_RST;
    clear_line_state();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset width: printable edges, unprintable bytes, a pair, CSI, stray leads
    seq = '{8'h41, 8'h7E, 8'h7F, 8'h00, 8'h1F, 8'hFF, 8'h80,
            CH_ESC, CH_LBRACKET, 8'h33, CH_SEMI, CH_M,
            8'hA4, CH_NL, 8'hB0, CH_ESC, 8'h78};
    foreach (seq[i]) push_byte(seq[i]);
    push_eoi();
    push_eoi();

    // narrow lines: ESC continues, newline eaten, other byte wraps
    write_width(8'd2);
    seq = '{8'h61, 8'h62, CH_ESC, 8'h63, 8'h64, 8'h65, CH_NL,
            8'h66, 8'h67, 8'h68, 8'h69, 8'hC1, 8'h42};
    foreach (seq[i]) push_byte(seq[i]);
    push_eoi();

    // sender mostly busy, receiver mostly idle
    write_width(8'd255);
    queue_forced_escape();
    queue_random(100);
    rx_hold = 400;
    write_width(8'd2);
    queue_random(100);

    // sender mostly idle, receiver mostly busy
    write_width(8'd0);
    tx_idle_pct = 74;
    rx_idle_pct = 16;
    queue_random(60);
    write_width(8'd1);
    queue_random(60);
    write_width(8'd40);
    queue_random(200);
    while (byte_q.size() > 150) @(negedge clk_i);
    hold_tx = 1'b1;
    while (in_busy || wrapped_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    hold_tx = 1'b0;

    // no idling
    write_width(8'($urandom_range(3, 254)));
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random(100);
    write_width(8'd255);
    queue_long_lines();
    queue_random(50);
    write_width(LINE_WIDTH_RST);
    queue_random(100);
    wait_drained();

    $display("Ran %0d input transfers over %0d widths: %0d lines, %0d end marks.",
             n_items, n_widths, n_lines, n_finish);
    $display("Pair splits %0d, byte-limit wraps %0d, input stall cycles %0d.",
             n_splits, n_forced, n_in_stalls);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("Timeout with %0d results outstanding.", wrapped_q.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/alw_pkg.sv
rtl/core/alw_front.sv
rtl/core/alw_queue.sv
rtl/core/alw_back.sv
rtl/core/ansi_aware_line_wrapper_top.sv
rtl/core/alw_checker.sv
tb/ansi_aware_line_wrapper_top_tb.sv
